FILE: src/stq_pkg.sv
// Shared constants, result codes and controller/datapath command and status types.
`default_nettype none

package stq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TPU_W         = 16;
    localparam int NOW_W         = 32;
    localparam int DELAY_W       = 24;
    localparam int TAG_W         = 8;
    localparam int PROD_W        = DELAY_W + TPU_W;

    localparam logic [TPU_W-1:0] TPU_RESET = 16'd10;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_INS,
        RES_REJ,
        RES_POP
    } res_t;

    typedef struct packed {
        logic idle;
        logic capture;
        logic mul;
        logic sum;
        logic walk_start;
        logic walk_step;
        logic place_after;
        logic place_head;
        logic rd_head;
        logic pop;
        logic load_out;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic req_valid;
        logic kind;
        logic empty;
        logic full;
        logic j_zero;
        logic shift;
        logic expired;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

FILE: src/stq_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none

interface stq_req_if
    import stq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [NOW_W-1:0]   now;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;

    modport source (output valid, output kind, output now, output delay, output tag,
                    input ready);
    modport sink   (input valid, input kind, input now, input delay, input tag,
                    output ready);
endinterface

interface stq_rsp_if
    import stq_pkg::*;
#(
    parameter int CW = $clog2(DEPTH_DEFAULT + 1)
)();
    logic             valid;
    logic             ready;
    logic             inserted;
    logic             full_reject;
    logic             expired_valid;
    logic [TAG_W-1:0] expired_tag;
    logic             queue_empty;
    logic [CW-1:0]    entry_count;

    modport source (output valid, output inserted, output full_reject,
                    output expired_valid, output expired_tag, output queue_empty,
                    output entry_count, input ready);
    modport sink   (input valid, input inserted, input full_reject,
                    input expired_valid, input expired_tag, input queue_empty,
                    input entry_count, output ready);
endinterface

interface stq_cfg_if
    import stq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TPU_W-1:0] ticks_per_unit;

    modport source (output valid, output ticks_per_unit, input ready);
    modport sink   (input valid, input ticks_per_unit, output ready);
endinterface

`default_nettype wire

FILE: src/sorted_timeout_queue_unit.sv
// Top level of the sorted timeout queue: controller and datapath.
//
// Usage:
//   req carries one request: kind (0 insert, 1 check), now, delay and tag.
//   rsp returns exactly one response per request: inserted, full_reject,
//   expired_valid, expired_tag, queue_empty and entry_count.
//   cfg writes ticks_per_unit; it is always ready, and the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   Entries live in a circular memory of DEPTH words with a head pointer, so a
//   pop is a single pointer advance. An insert walks from the tail toward the
//   head, one memory read and one write per cycle, moving each later entry up.
// Steps from request accepted to response valid: check: decode and head read,
//   compare, finish (decode, finish when empty); insert when full: decode,
//   finish; insert: decode and multiply, sum, walk start, k walk steps, place,
//   finish (no walk when empty), k = entries moved by the walk (0 .. held count,
//   at most DEPTH - 1). A new request is taken once the previous one has reached
//   the response register, even while that response still waits to be taken.
// Reset: the queue is empty and ticks_per_unit is 10. No memory clearing.
// Stall: a held response stops the next request in its final step until rsp
//   is taken; no response is dropped or repeated.
`default_nettype none

module sorted_timeout_queue_unit
    import stq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)(
    input  wire logic clk,
    input  wire logic rst_n,
    stq_req_if.sink   req,
    stq_rsp_if.source rsp,
    stq_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;

    stq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    stq_datapath #(
        .DEPTH (DEPTH),
        .CW    ($clog2(DEPTH + 1))
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

`default_nettype wire

FILE: src/stq_ctrl.sv
// Sequencing state machine for insert walks and expiry checks.
`default_nettype none

module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SUM,
        S_INS_START,
        S_WALK,
        S_PLACE,
        S_CHK_CMP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle    = 1'b1;
                cmd.capture = sts.req_valid;
                if (sts.req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.kind)
                begin
                    if (sts.empty)
                    begin
                        res_next   = RES_NONE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_CHK_CMP;
                    end
                end
                else if (sts.full)
                begin
                    res_next   = RES_REJ;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_INS_START;
            end
            S_INS_START:
            begin
                res_next = RES_INS;
                if (sts.empty)
                begin
                    cmd.place_head = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.shift)
                begin
                    cmd.walk_step = 1'b1;
                    if (sts.j_zero)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    cmd.place_after = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_PLACE:
            begin
                cmd.place_head = 1'b1;
                state_next     = S_FINISH;
            end
            S_CHK_CMP:
            begin
                if (sts.expired)
                begin
                    cmd.pop  = 1'b1;
                    res_next = RES_POP;
                end
                else
                begin
                    res_next = RES_NONE;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/stq_datapath.sv
// Entry memory, head pointer, count, deadline arithmetic and response register.
`default_nettype none

module stq_datapath
    import stq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stq_req_if.sink    req,
    stq_rsp_if.source  rsp,
    stq_cfg_if.sink    cfg,
    input  wire cmd_t  cmd,
    output sts_t       sts
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

    logic [TPU_W-1:0]   tpu_reg;
    logic               kind_reg;
    logic [NOW_W-1:0]   now_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [NOW_W-1:0]   prod_reg;
    logic [NOW_W-1:0]   dl_reg;
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      j_reg;

    logic [NOW_W-1:0]   dl_mem [DEPTH];
    logic [TAG_W-1:0]   tag_mem [DEPTH];
    logic [NOW_W-1:0]   rd_dl_reg;
    logic [TAG_W-1:0]   rd_tag_reg;

    logic               out_valid_reg;
    logic               out_ins_reg;
    logic               out_rej_reg;
    logic               out_ev_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic               out_empty_reg;
    logic [CW-1:0]      out_count_reg;

    logic [PROD_W-1:0]  prod_full;
    logic               rd_en;
    logic [AW-1:0]      rd_log;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_log;
    logic [AW-1:0]      wr_addr;
    logic [NOW_W-1:0]   wr_dl;
    logic [TAG_W-1:0]   wr_tag;
    logic [AW-1:0]      last_log;

    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [AW-1:0] lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    assign prod_full = delay_reg * tpu_reg;
    assign last_log  = AW'(count_reg - CW'(1));

    assign rd_en   = cmd.rd_head | cmd.walk_start | cmd.walk_step;
    assign rd_log  = cmd.rd_head    ? '0 :
                     cmd.walk_start ? last_log : (j_reg - AW'(1));
    assign rd_addr = to_phys(head_reg, rd_log);

    assign wr_en   = cmd.walk_step | cmd.place_after | cmd.place_head;
    assign wr_log  = cmd.place_head ? '0 : (j_reg + AW'(1));
    assign wr_addr = to_phys(head_reg, wr_log);
    assign wr_dl   = cmd.walk_step ? rd_dl_reg : dl_reg;
    assign wr_tag  = cmd.walk_step ? rd_tag_reg : tag_reg;

    always_comb
    begin
        sts.req_valid = req.valid;
        sts.kind      = kind_reg;
        sts.empty     = (count_reg == '0);
        sts.full      = (count_reg == CW'(DEPTH));
        sts.j_zero    = (j_reg == '0);
        sts.shift     = (j_reg == '0) ? (rd_dl_reg > dl_reg) : (rd_dl_reg >= dl_reg);
        sts.expired   = (rd_dl_reg <= now_reg);
        sts.out_busy  = out_valid_reg & ~rsp.ready;
    end

    assign req.ready = cmd.idle;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TPU_RESET;
        end
        else if (cfg.valid)
        begin
            tpu_reg <= cfg.ticks_per_unit;
        end
    end

    // hold the request payload and run the deadline arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= req.kind;
            now_reg   <= req.now;
            delay_reg <= req.delay;
            tag_reg   <= req.tag;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[NOW_W-1:0];
        end
        if (cmd.sum)
        begin
            dl_reg <= now_reg + prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (cmd.walk_start)
            begin
                j_reg <= last_log;
            end
            else if (cmd.walk_step)
            begin
                j_reg <= j_reg - AW'(1);
            end
            if (cmd.place_after || cmd.place_head)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
                head_reg  <= (head_reg == LAST) ? '0 : (head_reg + AW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dl_mem[wr_addr]  <= wr_dl;
            tag_mem[wr_addr] <= wr_tag;
        end
        if (rd_en)
        begin
            rd_dl_reg  <= dl_mem[rd_addr];
            rd_tag_reg <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ins_reg   <= (cmd.res == RES_INS);
            out_rej_reg   <= (cmd.res == RES_REJ);
            out_ev_reg    <= (cmd.res == RES_POP);
            out_tag_reg   <= (cmd.res == RES_POP) ? rd_tag_reg : '0;
            out_empty_reg <= (count_reg == '0);
            out_count_reg <= count_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.inserted      = out_ins_reg;
    assign rsp.full_reject   = out_rej_reg;
    assign rsp.expired_valid = out_ev_reg;
    assign rsp.expired_tag   = out_tag_reg;
    assign rsp.queue_empty   = out_empty_reg;
    assign rsp.entry_count   = out_count_reg;

endmodule

`default_nettype wire

FILE: src/stq_checker.sv
// Port-level checks on the response channel, bound to the top level.
`default_nettype none

module stq_checker
    import stq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
)(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             valid,
    input wire logic             ready,
    input wire logic             inserted,
    input wire logic             full_reject,
    input wire logic             expired_valid,
    input wire logic [TAG_W-1:0] expired_tag,
    input wire logic             queue_empty,
    input wire logic [CW-1:0]    entry_count
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(entry_count) && $stable(expired_tag))
        else $error("response changed while stalled");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $onehot0({inserted, full_reject, expired_valid}))
        else $error("more than one outcome flagged");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (queue_empty == (entry_count == '0)))
        else $error("queue_empty disagrees with entry_count");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (entry_count <= CW'(DEPTH)))
        else $error("entry_count above depth");

    a_tag: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !expired_valid |-> (expired_tag == '0))
        else $error("expired_tag set without a pop");

endmodule

bind sorted_timeout_queue_unit stq_checker #(
    .DEPTH (DEPTH),
    .CW    ($clog2(DEPTH + 1))
) u_stq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (rsp.valid),
    .ready         (rsp.ready),
    .inserted      (rsp.inserted),
    .full_reject   (rsp.full_reject),
    .expired_valid (rsp.expired_valid),
    .expired_tag   (rsp.expired_tag),
    .queue_empty   (rsp.queue_empty),
    .entry_count   (rsp.entry_count)
);

`default_nettype wire
